@@ hw/rtl/rfm_pkg.sv @@
// Shared types and constants for the ring FIFO with running minimum.
`default_nettype none

package rfm_pkg;

    localparam int DATA_W    = 32;
    localparam int CAP_W     = 5;
    localparam int DEPTH_DEF = 16;
    localparam int CAP_RESET = 10;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        ACT_ENQ = 1'b0,
        ACT_DEQ = 1'b1
    } t_action;

    typedef struct packed {
        logic                     action;
        logic signed [DATA_W-1:0] value;
    } t_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] popped_value;
        t_status                  status;
        logic [CAP_W-1:0]         occupancy;
        logic signed [DATA_W-1:0] min_value;
        logic                     min_valid;
    } t_result;

    typedef struct packed {
        logic capture;
        logic exec;
        logic scan;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_done;
    } t_dp_sts;

endpackage

`default_nettype wire

@@ hw/rtl/rfm_ctrl.sv @@
// Controller state machine: sequences update, ring walk and result strobe.
`default_nettype none

module rfm_ctrl
    import rfm_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    start,
    output logic         busy,
    output logic         o_strobe,
    output t_dp_cmd      o_cmd,
    input  wire t_dp_sts i_sts
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN
    } t_state;

    t_state r_state;
    logic   r_busy;
    logic   r_strobe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_busy   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start && !r_busy) begin
                        r_state <= S_EXEC;
                        r_busy  <= 1'b1;
                    end
                end
                S_EXEC: begin
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    // The last outstanding compare completes at this edge.
                    if (i_sts.scan_done) begin
                        r_state  <= S_IDLE;
                        r_busy   <= 1'b0;
                        r_strobe <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd.capture = (r_state == S_IDLE) && start && !r_busy;
        o_cmd.exec    = (r_state == S_EXEC);
        o_cmd.scan    = (r_state == S_SCAN);
    end

    assign busy     = r_busy;
    assign o_strobe = r_strobe;

endmodule

`default_nettype wire

@@ hw/rtl/rfm_dp.sv @@
// Datapath: entry memory, ring pointers, capacity register and minimum walk.
`default_nettype none

module rfm_dp
    import rfm_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CAP_W-1:0] i_cfg_wdata,
    input  wire t_item            i_item,
    input  wire t_dp_cmd          i_cmd,
    output t_dp_sts               o_sts,
    output t_result               o_res
);

    localparam int IW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW      = (IW + 1 > CAP_W) ? IW + 1 : CAP_W;
    localparam int CAP_LIM = (DEPTH < (2 ** CAP_W) - 1) ? DEPTH : (2 ** CAP_W) - 1;
    localparam int CAP_RST = (CAP_RESET > CAP_LIM) ? CAP_LIM : CAP_RESET;
    localparam logic [CAP_W-1:0] CAP_MAX  = CAP_W'(CAP_LIM);
    localparam logic [CAP_W-1:0] CAP_INIT = CAP_W'(CAP_RST);

    logic signed [DATA_W-1:0] mem [DEPTH];

    logic                     r_action;
    logic signed [DATA_W-1:0] r_value;
    logic [CAP_W-1:0]         r_cap;
    logic [IW-1:0]            r_head;
    logic [IW-1:0]            r_tail;
    logic [CAP_W-1:0]         r_count;
    logic [IW-1:0]            r_scan_ptr;
    logic [CAP_W-1:0]         r_scan_left;
    logic signed [DATA_W-1:0] r_rd_data;
    logic                     r_pop_vld;
    logic                     r_scan_vld;
    logic                     r_first;
    logic signed [DATA_W-1:0] r_min;
    logic signed [DATA_W-1:0] r_popped;
    t_status                  r_status;

    logic             enq_ok;
    logic             deq_ok;
    logic             scan_issue;
    logic [IW-1:0]    n_head;
    logic [IW-1:0]    n_tail;
    logic [CAP_W-1:0] n_count;
    logic [CAP_W-1:0] n_cap;
    logic [IW-1:0]    rd_addr;
    t_status          n_status;

    // Next slot in ring order, wrapping at the capacity in use.
    function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] idx,
                                                input logic [CAP_W-1:0] cap);
        logic [CW-1:0] inc;
        inc = CW'(idx) + CW'(1);
        return (inc >= CW'(cap)) ? '0 : idx + 1'b1;
    endfunction

    always_comb begin
        enq_ok     = (r_action == ACT_ENQ) && (r_count < r_cap);
        deq_ok     = (r_action == ACT_DEQ) && (r_count != '0);
        scan_issue = i_cmd.scan && (r_scan_left != '0);
        n_head     = deq_ok ? ring_next(r_head, r_cap) : r_head;
        n_tail     = enq_ok ? ring_next(r_tail, r_cap) : r_tail;
        priority if (enq_ok) begin
            n_count = r_count + 1'b1;
        end else if (deq_ok) begin
            n_count = r_count - 1'b1;
        end else begin
            n_count = r_count;
        end
        priority if (enq_ok || deq_ok) begin
            n_status = STATUS_OK;
        end else if (r_action == ACT_ENQ) begin
            n_status = STATUS_FULL;
        end else begin
            n_status = STATUS_EMPTY;
        end
        priority if (i_cfg_wdata == '0) begin
            n_cap = CAP_W'(1);
        end else if (i_cfg_wdata > CAP_MAX) begin
            n_cap = CAP_MAX;
        end else begin
            n_cap = i_cfg_wdata;
        end
        rd_addr = i_cmd.exec ? r_head : r_scan_ptr;
    end

    // Single-port entry store with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && enq_ok) begin
            mem[r_tail] <= r_value;
        end
        if ((i_cmd.exec && deq_ok) || scan_issue) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap      <= CAP_INIT;
            r_head     <= '0;
            r_tail     <= '0;
            r_count    <= '0;
            r_pop_vld  <= 1'b0;
            r_scan_vld <= 1'b0;
        end else begin
            r_pop_vld  <= i_cmd.exec && deq_ok;
            r_scan_vld <= scan_issue;
            if (i_cfg_we) begin
                // A new capacity empties the queue so that the ring stays consistent.
                r_cap   <= n_cap;
                r_head  <= '0;
                r_tail  <= '0;
                r_count <= '0;
            end else if (i_cmd.exec) begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= i_item.action;
            r_value  <= i_item.value;
        end
        if (i_cmd.exec) begin
            r_status    <= n_status;
            r_popped    <= '0;
            r_min       <= '0;
            r_first     <= 1'b1;
            r_scan_ptr  <= n_head;
            r_scan_left <= n_count;
        end
        if (scan_issue) begin
            r_scan_ptr  <= ring_next(r_scan_ptr, r_cap);
            r_scan_left <= r_scan_left - 1'b1;
        end
        if (r_pop_vld) begin
            r_popped <= r_rd_data;
        end
        if (r_scan_vld) begin
            r_first <= 1'b0;
            if (r_first || (r_rd_data < r_min)) begin
                r_min <= r_rd_data;
            end
        end
    end

    assign o_sts.scan_done = (r_scan_left == '0);

    always_comb begin
        o_res.popped_value = r_popped;
        o_res.status       = r_status;
        o_res.occupancy    = r_count;
        o_res.min_value    = r_min;
        o_res.min_valid    = (r_count != '0);
    end

endmodule

`default_nettype wire

@@ hw/rtl/ring_fifo_with_min_unit.sv @@
// Top level of the ring FIFO with running minimum: controller plus datapath.
//
//  channel   direction  handshake                      payload
//  command   in         start, busy (taken: start & !busy)  i_item (t_item)
//  result    out        o_res_valid, one cycle         o_res (t_result)
//  config    in         i_cfg_we, always taken         i_cfg_wdata (capacity)
//
// After acceptance the queue is updated (S_EXEC), then the live entries are walked one per
// cycle (S_SCAN) through the single read port of the entry memory; the walk covers the
// occupancy after the update, and the next transaction is accepted only once it is done.
// The result strobe comes at the end of the walk; busy is already low in that cycle.
// Reset empties the queue and sets the capacity to 10; no clearing pass is needed.
// The receiver cannot stall, so each result is shown for exactly one cycle.
`default_nettype none

module ring_fifo_with_min_unit
    import rfm_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire t_item            i_item,
    output logic                  o_res_valid,
    output t_result               o_res,
    input  wire logic             i_cfg_we,
    input  wire logic [CAP_W-1:0] i_cfg_wdata
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    rfm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .o_strobe (o_res_valid),
        .o_cmd    (cmd),
        .i_sts    (sts)
    );

    rfm_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (i_item),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire

@@ hw/rtl/rfm_checker.sv @@
// Port-level checker for the ring FIFO with running minimum, bound to the top level.
`default_nettype none

module rfm_checker
    import rfm_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire logic             o_res_valid,
    input wire t_result          o_res
);

    // An accepted transaction keeps the block busy in the following cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after an accepted transaction");

    // A result is only strobed once the block has released busy.
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> !busy)
        else $error("result strobed while busy");

    // The minimum is valid exactly when entries are held, and zero otherwise.
    a_min_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> ((o_res.min_valid == (o_res.occupancy != '0)) &&
                         (o_res.min_valid || (o_res.min_value == '0))))
        else $error("minimum does not match occupancy");

    // A refused transaction pops nothing.
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.status != STATUS_OK)) |-> (o_res.popped_value == '0))
        else $error("refused transaction returned a popped value");

    // A strobe lasts one cycle, since each transaction passes through S_EXEC and S_SCAN.
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> !o_res_valid)
        else $error("result strobe longer than one cycle");

endmodule

bind ring_fifo_with_min_unit rfm_checker u_rfm_checker (.*);

`default_nettype wire

@@ tb/ring_fifo_with_min_unit_tb.sv @@
// Self-checking testbench for the ring FIFO with running minimum.
`default_nettype none

module ring_fifo_with_min_unit_tb
    import rfm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    t_item            i_item;
    logic             o_res_valid;
    t_result          o_res;
    logic             i_cfg_we;
    logic [CAP_W-1:0] i_cfg_wdata;

    ring_fifo_with_min_unit #(.DEPTH(DEPTH_DEF)) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Our own copy of the queue, used to work out each awaited result.
    logic signed [DATA_W-1:0] q_words [DEPTH_DEF];
    int                       q_head;
    int                       q_tail;
    int                       q_count;
    int                       q_cap;

    t_result awaited_results [$];
    int      mismatch_count = 0;
    int      burst_left     = 0;

    function automatic int ring_advance(int idx);
        return (idx + 1 >= q_cap) ? 0 : idx + 1;
    endfunction

    function automatic t_result predict_fifo_step(t_item it);
        t_result r;
        int      idx;
        int      k;
        r = '0;
        r.status = STATUS_OK;
        if (it.action == ACT_ENQ) begin
            if (q_count >= q_cap) begin
                r.status = STATUS_FULL;
            end else begin
                q_words[q_tail] = it.value;
                q_tail = ring_advance(q_tail);
                q_count++;
            end
        end else begin
            if (q_count == 0) begin
                r.status = STATUS_EMPTY;
            end else begin
                r.popped_value = q_words[q_head];
                q_head = ring_advance(q_head);
                q_count--;
            end
        end
        r.occupancy = q_count[CAP_W-1:0];
        if (q_count > 0) begin
            // Walk the live words in ring order from the head.
            idx = q_head;
            r.min_value = q_words[idx];
            for (k = 1; k < q_count; k++) begin
                idx = ring_advance(idx);
                if (q_words[idx] < r.min_value) begin
                    r.min_value = q_words[idx];
                end
            end
            r.min_valid = 1'b1;
        end
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [DATA_W-1:0] got_v,
                                   logic [DATA_W-1:0] exp_v);
        $display("mismatch on %s: got %h, expected %h (t=%0t)", field, got_v, exp_v, $realtime);
        mismatch_count++;
    endtask

    // Every strobed result is compared with the oldest awaited one.
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n === 1'b1 && o_res_valid === 1'b1) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("unrequested result", o_res.popped_value, '0);
            end else begin
                exp_r = awaited_results.pop_front();
                if (o_res.popped_value !== exp_r.popped_value)
                    report_mismatch("popped_value", o_res.popped_value, exp_r.popped_value);
                if (o_res.status !== exp_r.status)
                    report_mismatch("status", DATA_W'(o_res.status),
                                    DATA_W'(exp_r.status));
                if (o_res.occupancy !== exp_r.occupancy)
                    report_mismatch("occupancy", DATA_W'(o_res.occupancy),
                                    DATA_W'(exp_r.occupancy));
                if (o_res.min_value !== exp_r.min_value)
                    report_mismatch("min_value", o_res.min_value, exp_r.min_value);
                if (o_res.min_valid !== exp_r.min_valid)
                    report_mismatch("min_valid", DATA_W'(o_res.min_valid),
                                    DATA_W'(exp_r.min_valid));
            end
        end
    end

    // Sends one transaction, then keeps to the burst and gap pattern of the sender.
    task automatic send_item(t_action act, logic signed [DATA_W-1:0] v);
        t_item it;
        int    gap;
        it.action = act;
        it.value  = v;
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        awaited_results.push_back(predict_fifo_step(it));
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            start  <= 1'b0;
            i_item <= t_item'({1'($urandom), $urandom});
            gap = $urandom_range(1, 14);
            repeat (gap) @(posedge i_clk);
            // Now and then a long stretch goes by without any gap.
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 90)
                                                      : $urandom_range(0, 12);
        end
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] v);
        start <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= CAP_W'($urandom);
        q_cap   = (v < 1) ? 1 : ((v > DEPTH_DEF) ? DEPTH_DEF : int'(v));
        q_head  = 0;
        q_tail  = 0;
        q_count = 0;
    endtask

    // Reset capacity: empty dequeue, fill with extremes, refuse when full.
    task automatic test_reset_state;
        send_item(ACT_DEQ, 32'sh1234_5678);
        send_item(ACT_ENQ, 32'sh0000_0001);
        send_item(ACT_ENQ, 32'sh7fff_ffff);
        send_item(ACT_ENQ, 32'sh8000_0000);
        send_item(ACT_ENQ, 32'sh0000_0000);
        send_item(ACT_ENQ, -32'sd1);
        send_item(ACT_ENQ, 32'sh5555_5555);
        send_item(ACT_ENQ, 32'shaaaa_aaaa);
        send_item(ACT_ENQ, 32'sh8000_0000);
        send_item(ACT_ENQ, 32'sh7fff_fffe);
        send_item(ACT_ENQ, -32'sd2);
        send_item(ACT_ENQ, 32'sh0bad_cafe);
        send_item(ACT_DEQ, -32'sd1);
        send_item(ACT_DEQ, 32'sh7fff_ffff);
        send_item(ACT_DEQ, 32'sh0000_0000);
    endtask

    // A write of zero while words are held empties the queue and gives capacity one.
    task automatic test_capacity_low;
        write_capacity(5'd0);
        send_item(ACT_ENQ, -32'sd7);
        send_item(ACT_ENQ, 32'sd7);
        send_item(ACT_DEQ, 32'sd0);
        send_item(ACT_DEQ, 32'sd0);
    endtask

    // A write above the depth is clamped to the full depth.
    task automatic test_capacity_high;
        write_capacity(5'd17);
        send_item(ACT_ENQ, 32'sd100);
        send_item(ACT_ENQ, -32'sd100);
        send_item(ACT_DEQ, 32'sd5);
    endtask

    task automatic test_random_traffic(logic [CAP_W-1:0] cap, int n_items);
        int                       k;
        int                       enq_pct;
        logic signed [DATA_W-1:0] v;
        t_action                  act;
        write_capacity(cap);
        for (k = 0; k < n_items; k++) begin
            // Alternate between filling and draining so both full and empty are hit.
            enq_pct = ((k / 40) % 2 == 0) ? 75 : 30;
            act = ($urandom_range(0, 99) < enq_pct) ? ACT_ENQ : ACT_DEQ;
            case ($urandom_range(0, 7))
                0: begin
                    case ($urandom_range(0, 3))
                        0: v = 32'sh8000_0000;
                        1: v = 32'sh7fff_ffff;
                        2: v = 32'sd0;
                        default: v = -32'sd1;
                    endcase
                end
                1, 2: v = $signed($urandom_range(0, 15)) - 32'sd8;
                default: v = $urandom;
            endcase
            send_item(act, v);
        end
    endtask

    initial begin
        int wait_cycles;
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_item      <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        q_cap   = CAP_RESET;
        q_head  = 0;
        q_tail  = 0;
        q_count = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_capacity_low();
        test_capacity_high();

        test_random_traffic(5'd1, 140);
        test_random_traffic(5'd2, 140);
        test_random_traffic(5'd16, 150);
        test_random_traffic(5'd31, 140);
        test_random_traffic(5'd0, 120);
        test_random_traffic(5'd3, 140);
        test_random_traffic(5'd7, 150);
        test_random_traffic(5'd10, 150);
        test_random_traffic(CAP_W'($urandom_range(0, 31)), 140);
        test_random_traffic(CAP_W'($urandom_range(0, 31)), 140);

        start <= 1'b0;
        wait_cycles = 0;
        while (awaited_results.size() != 0 && wait_cycles < 2000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        if (awaited_results.size() != 0) begin
            report_mismatch("results never arrived", awaited_results.size(), '0);
        end
        repeat (30) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[ring_fifo_with_min_unit] OK");
        end else begin
            $display("[ring_fifo_with_min_unit] ERROR");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("[ring_fifo_with_min_unit] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
